// ===== hdl/bvm_pkg.sv =====
// ---------------------------------------------------------------------------
// bvm_pkg
// Shared types, widths, constants and codes of the validated bus voltage
// measurement pipeline.
// ---------------------------------------------------------------------------
package bvm_pkg;

	// converter and calibration constants
	localparam int unsigned ADC_TOP_CODE  = 4095;
	localparam int unsigned CAL_SUPPLY_MV = 3000;

	// field widths
	localparam int RAW_W   = 12;
	localparam int STAMP_W = 32;
	localparam int REG16_W = 16;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int ERR_W   = 4;
	localparam int SUP_W   = 16;
	localparam int BUS_W   = 20;

	// internal widths
	localparam int NUM_W    = 28;               // cal supply * reference calibration
	localparam int BD_W     = RAW_W + REG16_W;  // bus count * divider ratio
	localparam int PROD_W   = BD_W + NUM_W;     // full bus numerator
	localparam int DEN_W    = RAW_W + REG16_W;  // reference count * full scale
	localparam int BUS_Q_W  = DEN_W;            // bus quotient before the q8 shift
	localparam int SUP_Q_W  = RAW_W;            // supply quotient
	localparam int DIV_STAGES = BUS_Q_W;

	// limit constants
	localparam logic [REG16_W-1:0] SUPPLY_FLOOR_MV = REG16_W'(1800);
	localparam logic [REG16_W-1:0] SUPPLY_CEIL_MV  = REG16_W'(3600);
	localparam logic [REG16_W-1:0] FULL_SCALE_C    = REG16_W'(ADC_TOP_CODE);
	localparam logic [NUM_W-1:0]   CAL_SUPPLY_C    = NUM_W'(CAL_SUPPLY_MV);
	localparam logic [NUM_W-1:0]   CAL_LOW_C       = NUM_W'(1170 * ADC_TOP_CODE);
	localparam logic [NUM_W-1:0]   CAL_HIGH_C      = NUM_W'(1250 * ADC_TOP_CODE);

	// register indexes
	localparam logic [IDX_W-1:0] REG_MAX_AGE    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MAX_SKEW   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_SUPPLY_MIN = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SUPPLY_MAX = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_REF_CAL    = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_DIVIDER    = IDX_W'(5);

	// register reset values
	localparam logic [CFG_W-1:0]   RST_MAX_AGE    = CFG_W'(1000);
	localparam logic [CFG_W-1:0]   RST_MAX_SKEW   = CFG_W'(100);
	localparam logic [REG16_W-1:0] RST_SUPPLY_MIN = REG16_W'(3000);
	localparam logic [REG16_W-1:0] RST_SUPPLY_MAX = REG16_W'(3600);
	localparam logic [REG16_W-1:0] RST_REF_CAL    = REG16_W'(1655);
	localparam logic [REG16_W-1:0] RST_DIVIDER    = REG16_W'(4864);

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK        = ERR_W'(0);
	localparam logic [ERR_W-1:0] ERR_LIMITS    = ERR_W'(1);
	localparam logic [ERR_W-1:0] ERR_MISSING   = ERR_W'(2);
	localparam logic [ERR_W-1:0] ERR_CAL       = ERR_W'(3);
	localparam logic [ERR_W-1:0] ERR_REF       = ERR_W'(4);
	localparam logic [ERR_W-1:0] ERR_BUS_SAT   = ERR_W'(5);
	localparam logic [ERR_W-1:0] ERR_STALE     = ERR_W'(6);
	localparam logic [ERR_W-1:0] ERR_SKEW      = ERR_W'(7);
	localparam logic [ERR_W-1:0] ERR_SUPPLY    = ERR_W'(8);

	// configuration register file contents
	typedef struct packed {
		logic [CFG_W-1:0]   age_limit_us;
		logic [CFG_W-1:0]   max_skew_us;
		logic [REG16_W-1:0] supply_min_mv;
		logic [REG16_W-1:0] supply_max_mv;
		logic [REG16_W-1:0] factory_ref_cal;
		logic [REG16_W-1:0] divider_ratio_q8;
	} cfg_t;

	// one word inside the divider pipeline; the low fields shift quotient bits in
	typedef struct packed {
		logic [ERR_W-1:0]   err;
		logic               sat;
		logic [DEN_W-1:0]   bus_rem;
		logic [BUS_Q_W-1:0] bus_low;
		logic [DEN_W-1:0]   bus_den;
		logic [RAW_W-1:0]   sup_rem;
		logic [SUP_Q_W-1:0] sup_low;
		logic [RAW_W-1:0]   sup_den;
	} div_word_t;

endpackage

// ===== hdl/bus_voltage_validated_measure_core.sv =====
// ---------------------------------------------------------------------------
// bus_voltage_validated_measure_core
// Validated bus voltage measurement from a bus ADC sample and an internal
// reference sample, with supply compensation.
// ---------------------------------------------------------------------------
// A command is taken on every clock edge where start is high; busy is never
// raised, so one sample pair can be issued each cycle. Each command returns
// exactly one word on done, after passing through three check stages, a
// 28-stage one-bit-per-stage divider pipeline and the output register. done
// is a single-cycle strobe and the word is not held: the receiver must
// capture it in that cycle. supply_mv and bus_mv read zero whenever
// error_code is not zero. Configuration writes take effect at once and
// should only be made while no command is in flight.
module bus_voltage_validated_measure_core import bvm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic [RAW_W-1:0]   bus_raw,
	input  logic               bus_ok,
	input  logic [STAMP_W-1:0] bus_stamp_us,
	input  logic [RAW_W-1:0]   ref_raw,
	input  logic               ref_ok,
	input  logic [STAMP_W-1:0] ref_stamp_us,
	input  logic [STAMP_W-1:0] now_stamp_us,
	output logic               done,
	output logic [ERR_W-1:0]   error_code,
	output logic [SUP_W-1:0]   supply_mv,
	output logic [BUS_W-1:0]   bus_mv
);

	cfg_t       cfg;
	logic       chk_valid, div_valid;
	div_word_t  chk_word, div_word;

	logic             done_q;
	logic [ERR_W-1:0] error_code_q;
	logic [SUP_W-1:0] supply_mv_q;
	logic [BUS_W-1:0] bus_mv_q;

	// the pipeline never stalls
	assign busy = 1'b0;

	bvm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bvm_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.bus_raw      (bus_raw),
		.bus_ok       (bus_ok),
		.bus_stamp_us (bus_stamp_us),
		.ref_raw      (ref_raw),
		.ref_ok       (ref_ok),
		.ref_stamp_us (ref_stamp_us),
		.now_stamp_us (now_stamp_us),
		.cfg          (cfg),
		.out_valid    (chk_valid),
		.out_word     (chk_word)
	);

	bvm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chk_valid),
		.in_word   (chk_word),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	// result word: drop the q8 fraction, saturate, zero on error
	always_ff @(posedge clk) begin
		error_code_q <= div_word.err;
		if (div_word.err == ERR_OK) begin
			supply_mv_q <= SUP_W'(div_word.sup_low);
			bus_mv_q    <= div_word.sat ? '1 : div_word.bus_low[BUS_Q_W-1 -: BUS_W];
		end else begin
			supply_mv_q <= '0;
			bus_mv_q    <= '0;
		end
	end

	assign done       = done_q;
	assign error_code = error_code_q;
	assign supply_mv  = supply_mv_q;
	assign bus_mv     = bus_mv_q;

endmodule

// ===== hdl/bvm_cfg.sv =====
// ---------------------------------------------------------------------------
// bvm_cfg
// Configuration register file with a plain write port; writes to unused
// indexes are dropped.
// ---------------------------------------------------------------------------
module bvm_cfg import bvm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.age_limit_us     <= RST_MAX_AGE;
			cfg_q.max_skew_us      <= RST_MAX_SKEW;
			cfg_q.supply_min_mv    <= RST_SUPPLY_MIN;
			cfg_q.supply_max_mv    <= RST_SUPPLY_MAX;
			cfg_q.factory_ref_cal  <= RST_REF_CAL;
			cfg_q.divider_ratio_q8 <= RST_DIVIDER;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_AGE:    cfg_q.age_limit_us     <= cfg_wdata;
				REG_MAX_SKEW:   cfg_q.max_skew_us      <= cfg_wdata;
				REG_SUPPLY_MIN: cfg_q.supply_min_mv    <= cfg_wdata[REG16_W-1:0];
				REG_SUPPLY_MAX: cfg_q.supply_max_mv    <= cfg_wdata[REG16_W-1:0];
				REG_REF_CAL:    cfg_q.factory_ref_cal  <= cfg_wdata[REG16_W-1:0];
				REG_DIVIDER:    cfg_q.divider_ratio_q8 <= cfg_wdata[REG16_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bvm_check.sv =====
// ---------------------------------------------------------------------------
// bvm_check
// Three-stage front end: sample ages, products and all validity checks,
// ending in the error code and the dividend and divisor words for the divider.
// ---------------------------------------------------------------------------
module bvm_check import bvm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [RAW_W-1:0]   bus_raw,
	input  logic               bus_ok,
	input  logic [STAMP_W-1:0] bus_stamp_us,
	input  logic [RAW_W-1:0]   ref_raw,
	input  logic               ref_ok,
	input  logic [STAMP_W-1:0] ref_stamp_us,
	input  logic [STAMP_W-1:0] now_stamp_us,
	input  cfg_t               cfg,
	output logic               out_valid,
	output div_word_t          out_word
);

	// stage 1 registers
	logic               valid_s1;
	logic [STAMP_W-1:0] bus_age_s1, ref_age_s1;
	logic               lim_bad_s1, miss_s1, ref_bad_s1, bus_sat_s1;
	logic [BD_W-1:0]    bd_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [DEN_W-1:0]   den_s1;
	logic [RAW_W-1:0]   ref_raw_s1;

	// stage 2 registers
	logic               valid_s2;
	logic               lim_bad_s2, miss_s2, ref_bad_s2, bus_sat_s2;
	logic               cal_bad_s2, stale_s2;
	logic [STAMP_W-1:0] skew_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [NUM_W-1:0]   num_s2, rmin_s2, rmax_s2;
	logic [DEN_W-1:0]   den_s2;
	logic [RAW_W-1:0]   ref_raw_s2;

	// stage 3 registers
	logic               valid_s3;
	div_word_t          word_s3;

	logic               lim_bad;
	logic [STAMP_W-1:0] skew;
	logic [ERR_W-1:0]   err;
	logic               skew_bad, range_bad;

	// configuration limit check
	always_comb begin
		lim_bad = (cfg.age_limit_us == '0) || cfg.age_limit_us[CFG_W-1] ||
			(cfg.max_skew_us > cfg.age_limit_us) ||
			(cfg.supply_min_mv < SUPPLY_FLOOR_MV) ||
			(cfg.supply_max_mv > SUPPLY_CEIL_MV) ||
			(cfg.supply_min_mv >= cfg.supply_max_mv);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: ages, flags and first products
	always_ff @(posedge clk) begin
		bus_age_s1 <= now_stamp_us - bus_stamp_us;
		ref_age_s1 <= now_stamp_us - ref_stamp_us;
		lim_bad_s1 <= lim_bad;
		miss_s1    <= !bus_ok || !ref_ok;
		ref_bad_s1 <= (ref_raw == '0) || (REG16_W'(ref_raw) >= FULL_SCALE_C);
		bus_sat_s1 <= REG16_W'(bus_raw) >= FULL_SCALE_C;
		bd_s1      <= BD_W'(bus_raw) * BD_W'(cfg.divider_ratio_q8);
		num_s1     <= CAL_SUPPLY_C * NUM_W'(cfg.factory_ref_cal);
		den_s1     <= DEN_W'(ref_raw) * DEN_W'(FULL_SCALE_C);
		ref_raw_s1 <= ref_raw;
	end

	// absolute age difference
	always_comb begin
		skew = (bus_age_s1 > ref_age_s1) ? bus_age_s1 - ref_age_s1
			: ref_age_s1 - bus_age_s1;
	end

	// stage 2: calibration and age checks, full numerator, supply window bounds
	always_ff @(posedge clk) begin
		lim_bad_s2 <= lim_bad_s1;
		miss_s2    <= miss_s1;
		ref_bad_s2 <= ref_bad_s1;
		bus_sat_s2 <= bus_sat_s1;
		cal_bad_s2 <= (num_s1 < CAL_LOW_C) || (num_s1 > CAL_HIGH_C);
		stale_s2   <= (bus_age_s1 > cfg.age_limit_us) || (ref_age_s1 > cfg.age_limit_us);
		skew_s2    <= skew;
		prod_s2    <= PROD_W'(bd_s1) * PROD_W'(num_s1);
		num_s2     <= num_s1;
		rmin_s2    <= NUM_W'(cfg.supply_min_mv) * NUM_W'(ref_raw_s1);
		rmax_s2    <= NUM_W'(cfg.supply_max_mv) * NUM_W'(ref_raw_s1);
		den_s2     <= den_s1;
		ref_raw_s2 <= ref_raw_s1;
	end

	// first failing check wins
	always_comb begin
		skew_bad  = skew_s2 > cfg.max_skew_us;
		range_bad = (num_s2 < rmin_s2) || (num_s2 > rmax_s2);
		if (lim_bad_s2)      err = ERR_LIMITS;
		else if (miss_s2)    err = ERR_MISSING;
		else if (cal_bad_s2) err = ERR_CAL;
		else if (ref_bad_s2) err = ERR_REF;
		else if (bus_sat_s2) err = ERR_BUS_SAT;
		else if (stale_s2)   err = ERR_STALE;
		else if (skew_bad)   err = ERR_SKEW;
		else if (range_bad)  err = ERR_SUPPLY;
		else                 err = ERR_OK;
	end

	// stage 3: error code and divider start words
	always_ff @(posedge clk) begin
		word_s3.err     <= err;
		word_s3.sat     <= prod_s2[PROD_W-1 -: DEN_W] >= den_s2;
		word_s3.bus_rem <= prod_s2[PROD_W-1 -: DEN_W];
		word_s3.bus_low <= prod_s2[BUS_Q_W-1:0];
		word_s3.bus_den <= den_s2;
		word_s3.sup_rem <= num_s2[SUP_Q_W +: RAW_W];
		word_s3.sup_low <= num_s2[SUP_Q_W-1:0];
		word_s3.sup_den <= ref_raw_s2;
	end

	assign out_valid = valid_s3;
	assign out_word  = word_s3;

endmodule

// ===== hdl/bvm_div.sv =====
// ---------------------------------------------------------------------------
// bvm_div
// Restoring divider pipeline, one quotient bit per stage. The bus lane runs
// through every stage; the supply lane finishes in its first stages and is
// then carried unchanged.
// ---------------------------------------------------------------------------
module bvm_div import bvm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	div_word_t             word_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] valid_s;
	div_word_t             feed [DIV_STAGES+1];
	logic [DIV_STAGES:0]   feed_valid;

	assign feed[0]       = in_word;
	assign feed_valid[0] = in_valid;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_W:0] t_bus, d_bus;
		logic           ge_bus;
		logic [RAW_W:0] t_sup, d_sup;
		logic           ge_sup;
		div_word_t      nxt;

		// one quotient bit for each lane
		always_comb begin
			nxt    = feed[k];
			t_bus  = {feed[k].bus_rem, feed[k].bus_low[BUS_Q_W-1]};
			ge_bus = t_bus >= {1'b0, feed[k].bus_den};
			d_bus  = t_bus - {1'b0, feed[k].bus_den};
			nxt.bus_rem = ge_bus ? d_bus[DEN_W-1:0] : t_bus[DEN_W-1:0];
			nxt.bus_low = {feed[k].bus_low[BUS_Q_W-2:0], ge_bus};
			t_sup  = {feed[k].sup_rem, feed[k].sup_low[SUP_Q_W-1]};
			ge_sup = t_sup >= {1'b0, feed[k].sup_den};
			d_sup  = t_sup - {1'b0, feed[k].sup_den};
			if (k < SUP_Q_W) begin
				nxt.sup_rem = ge_sup ? d_sup[RAW_W-1:0] : t_sup[RAW_W-1:0];
				nxt.sup_low = {feed[k].sup_low[SUP_Q_W-2:0], ge_sup};
			end
		end

		// stage valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= feed_valid[k];
			end
		end

		// stage word
		always_ff @(posedge clk) begin
			word_s[k] <= nxt;
		end

		assign feed[k+1]       = word_s[k];
		assign feed_valid[k+1] = valid_s[k];
	end

	assign out_valid = feed_valid[DIV_STAGES];
	assign out_word  = feed[DIV_STAGES];

endmodule
